[rtl/plu_pkg.sv]
// Shared codes and the sequencer state type for the positional list engine.
package plu_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_UP_TAIL,
        S_PUT,
        S_DOWN,
        S_DOWN_TAIL,
        S_SCAN
    } state_t;

endpackage

[rtl/positional_list_engine_unit.sv]
// Positional list engine: ordered value list with insert, remove and search.
//
//  channel   direction  handshake             word
//  request   in         start & !busy         req_type, position, value
//  result    out        done (one cycle)      status, found, found_index, count
//
// One memory port pair does all the work: one read and one write per cycle,
// read data registered. An insert below the count shifts the entries from its
// index one place up, from the last back, then writes; an append just writes.
// A remove below the last shifts later entries down; a search reads from index
// 0 to a hit or the last entry. Ignored and refused requests, removal of the
// last entry and empty-list searches answer in the cycle after acceptance.
// Reset leaves the list empty; no clearing pass is needed.
// busy is high while a request is under way; results cannot be stalled.
module positional_list_engine_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    req_type,
    input  logic signed [7:0]             position,
    input  logic signed [31:0]            value,
    output logic                          done,
    output logic [1:0]                    status,
    output logic                          found,
    output logic [$clog2(CAPACITY)-1:0]   found_index,
    output logic [$clog2(CAPACITY+1)-1:0] count
);
    import plu_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 7) ? CW : 7;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [AW-1:0]   wa_reg, wa_next;
    logic [AW-1:0]   at_reg, at_next;
    logic            pend_reg, pend_next;
    logic [31:0]     val_reg, val_next;
    logic            done_reg, done_next;
    logic [1:0]      status_reg, status_next;
    logic            found_reg, found_next;
    logic [AW-1:0]   fidx_reg, fidx_next;

    logic [31:0]     mem [CAPACITY];
    logic [31:0]     rdata_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;
    logic [31:0]     mem_wdata;

    logic            accept;
    logic [PW-1:0]   pos_ext;
    logic [PW-1:0]   cnt_ext;
    logic            pos_below_cnt;
    logic [AW-1:0]   last_idx;

    assign accept        = start && (state_reg == S_IDLE);
    assign pos_ext       = PW'(position[6:0]);
    assign cnt_ext       = PW'(count_reg);
    assign pos_below_cnt = !position[7] && (pos_ext < cnt_ext);
    assign last_idx      = AW'(count_reg - CW'(1));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        wa_reg     <= wa_next;
        at_reg     <= at_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        fidx_reg   <= fidx_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        wa_next     = wa_reg;
        at_next     = at_reg;
        pend_next   = pend_reg;
        val_next    = val_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        found_next  = found_reg;
        fidx_next   = fidx_reg;
        mem_we      = 1'b0;
        mem_waddr   = wa_reg;
        mem_wdata   = rdata_reg;
        mem_raddr   = ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    val_next    = value;
                    pend_next   = 1'b0;
                    status_next = ST_DONE;
                    found_next  = 1'b0;
                    fidx_next   = '0;
                    case (req_type)
                        REQ_INSERT:
                        begin
                            if (position[7] && (position != -8'sd1))
                            begin
                                status_next = ST_IGNORED;
                                done_next   = 1'b1;
                            end
                            else if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                                done_next   = 1'b1;
                            end
                            else if (pos_below_cnt)
                            begin
                                // open a gap: shift the tail back from the end
                                at_next    = AW'(position[6:0]);
                                ptr_next   = last_idx;
                                state_next = S_UP;
                            end
                            else
                            begin
                                at_next    = AW'(count_reg);
                                state_next = S_PUT;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (!pos_below_cnt)
                            begin
                                status_next = ST_IGNORED;
                                done_next   = 1'b1;
                            end
                            else if (AW'(position[6:0]) == last_idx)
                            begin
                                count_next = count_reg - CW'(1);
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = AW'(position[6:0]) + AW'(1);
                                state_next = S_DOWN;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = ST_IGNORED;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                // write last word read one place up, read the next one down
                mem_we    = pend_reg;
                wa_next   = ptr_reg + AW'(1);
                pend_next = 1'b1;
                ptr_next  = ptr_reg - AW'(1);
                if (ptr_reg == at_reg)
                begin
                    state_next = S_UP_TAIL;
                end
            end
            S_UP_TAIL:
            begin
                mem_we     = 1'b1;
                state_next = S_PUT;
            end
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = at_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_DOWN:
            begin
                mem_we    = pend_reg;
                wa_next   = ptr_reg - AW'(1);
                pend_next = 1'b1;
                ptr_next  = ptr_reg + AW'(1);
                if (ptr_reg == last_idx)
                begin
                    state_next = S_DOWN_TAIL;
                end
            end
            S_DOWN_TAIL:
            begin
                mem_we     = 1'b1;
                count_next = count_reg - CW'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (pend_reg && (rdata_reg == val_reg))
                begin
                    found_next = 1'b1;
                    fidx_next  = wa_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (pend_reg && (wa_reg == last_idx))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // wa tracks the index of the word arriving next cycle
                    wa_next   = ptr_reg;
                    pend_next = 1'b1;
                    ptr_next  = ptr_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign found_index = fidx_reg;
    assign count       = count_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a request is still running");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> done_reg &&
            ((count_reg == $past(count_reg) + CW'(1)) ||
             (count_reg == $past(count_reg) - CW'(1))))
        else $error("entry count moved without a result or by more than one");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == ST_DONE) && (CW'(found_index) < count))
        else $error("search hit reported with bad status or index");

    a_start_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request neither running nor answered");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the positional list engine: directed, capacity, quiet-sender and random requests.
module tb_top;
    import plu_pkg::*;

    localparam int         CAP          = 64;
    localparam logic [1:0] REQ_SPARE    = 2'd3;
    localparam int         RANDOM_ITEMS = 1350;
    localparam int         CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [5:0] found_index;
        logic [6:0] count;
    } list_reply_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               start    = 1'b0;
    logic [1:0]         req_type = REQ_INSERT;
    logic signed [7:0]  position = '0;
    logic signed [31:0] value    = '0;
    logic               busy;
    logic               done;
    logic [1:0]         status;
    logic               found;
    logic [5:0]         found_index;
    logic [6:0]         count;

    logic [31:0] shadow_list [CAP];
    int          shadow_count = 0;
    list_reply_t pending_replies [$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    bit          steady = 1'b0;

    positional_list_engine_unit #(.CAPACITY(CAP)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .position    (position),
        .value       (value),
        .done        (done),
        .status      (status),
        .found       (found),
        .found_index (found_index),
        .count       (count)
    );

    always #2 clk = ~clk;

    // Apply one request to the shadow list and return the reply it must produce.
    function automatic list_reply_t predict_reply(input logic [1:0] kind,
                                                  input logic signed [7:0] pos,
                                                  input logic [31:0] val);
        list_reply_t r;
        int          p;
        int          at;
        int          i;
        r        = '0;
        r.status = ST_DONE;
        p        = int'(pos);
        case (kind)
            REQ_INSERT:
            begin
                if (p < -1)
                    r.status = ST_IGNORED;
                else if (shadow_count >= CAP)
                    r.status = ST_FULL;
                else
                begin
                    at = (p == -1 || p >= shadow_count) ? shadow_count : p;
                    for (i = shadow_count; i > at; i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[at] = val;
                    shadow_count++;
                end
            end
            REQ_REMOVE:
            begin
                if (p < 0 || p >= shadow_count)
                    r.status = ST_IGNORED;
                else
                begin
                    for (i = p; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i + 1];
                    shadow_count--;
                end
            end
            REQ_SEARCH:
            begin
                for (i = 0; i < shadow_count && !r.found; i++)
                    if (shadow_list[i] == val)
                    begin
                        r.found       = 1'b1;
                        r.found_index = 6'(i);
                    end
            end
            default:
                r.status = ST_IGNORED;
        endcase
        r.count = 7'(shadow_count);
        return r;
    endfunction

    // Mostly fresh values, with a share drawn from a small pool so duplicates turn up.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9, 0))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'(($urandom_range(7, 0)));
            default: return $urandom;
        endcase
    endfunction

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input logic [1:0] kind, input logic signed [7:0] pos,
                             input logic [31:0] val);
        if (!steady && $urandom_range(99, 0) < 9)
        begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= kind;
        position <= pos;
        value    <= val;
        do @(posedge clk); while (busy);
        pending_replies.push_back(predict_reply(kind, pos, val));
    endtask

    task automatic wait_for_replies();
        start <= 1'b0;
        do @(posedge clk); while (pending_replies.size() != 0);
    endtask

    task automatic test_directed();
        send_word(REQ_SEARCH, 0, 32'h0);             // search of an empty list
        send_word(REQ_REMOVE, 0, 32'h0);             // remove from an empty list
        send_word(REQ_INSERT, 0, 32'h8000_0000);     // front of an empty list
        send_word(REQ_INSERT, -1, 32'h7FFF_FFFF);
        send_word(REQ_INSERT, 127, 32'hFFFF_FFFF);   // past the end: append
        send_word(REQ_INSERT, 0, 32'h0);
        send_word(REQ_INSERT, 2, 32'h7FFF_FFFF);
        send_word(REQ_INSERT, -2, 32'h1234_5678);
        send_word(REQ_INSERT, -128, 32'h1234_5678);
        send_word(REQ_INSERT, 5, 32'h5555_5555);     // exactly at count
        send_word(REQ_SEARCH, 0, 32'h7FFF_FFFF);     // first of two copies
        send_word(REQ_SEARCH, 0, 32'hAAAA_AAAA);
        send_word(REQ_SEARCH, 0, 32'h5555_5555);
        send_word(REQ_SPARE, 0, 32'h0);
        send_word(REQ_SPARE, -1, 32'hFFFF_FFFF);
        send_word(REQ_REMOVE, -1, 32'h0);
        send_word(REQ_REMOVE, -128, 32'h0);
        send_word(REQ_REMOVE, 127, 32'h0);
        send_word(REQ_REMOVE, 6, 32'h0);             // one past the last entry
        send_word(REQ_REMOVE, 2, 32'h0);
        send_word(REQ_REMOVE, 0, 32'h0);
        send_word(REQ_REMOVE, 3, 32'h0);
        repeat (3) send_word(REQ_REMOVE, 0, 32'h0);  // last one empties the list
        send_word(REQ_SEARCH, 0, 32'h0);
    endtask

    // Fill to capacity, poke the full list, then drain it again.
    task automatic test_capacity();
        while (shadow_count < CAP)
            send_word(REQ_INSERT, 8'(int'($urandom_range(shadow_count + 1, 0)) - 1),
                      pick_value());
        send_word(REQ_INSERT, -1, $urandom);
        send_word(REQ_INSERT, 0, $urandom);
        send_word(REQ_INSERT, 127, $urandom);
        send_word(REQ_INSERT, -2, $urandom);          // ignored wins over full
        send_word(REQ_SEARCH, 0, shadow_list[CAP - 1]);
        send_word(REQ_SEARCH, 0, $urandom);
        send_word(REQ_REMOVE, CAP, 32'h0);
        while (shadow_count > 0)
        begin
            if ($urandom_range(3, 0) == 0)
                send_word(REQ_SEARCH, 0, shadow_list[$urandom_range(shadow_count - 1, 0)]);
            send_word(REQ_REMOVE, 8'($urandom_range(shadow_count - 1, 0)), $urandom);
        end
    endtask

    task automatic test_random();
        int  n;
        int  roll;
        int  insert_share;
        int  remove_share;
        bit  grow;
        grow = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 500 && n < 800);
            if (shadow_count == CAP || (shadow_count > 8 && $urandom_range(199, 0) == 0))
                grow = 1'b0;
            else if (shadow_count == 0 || $urandom_range(199, 0) == 0)
                grow = 1'b1;
            insert_share = grow ? 55 : 25;
            remove_share = grow ? 20 : 50;
            roll         = $urandom_range(99, 0);
            if (roll < 8)
                send_word(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)), $urandom);
            else if (roll < 8 + insert_share)
                send_word(REQ_INSERT,
                          8'(($urandom_range(3, 0) == 0) ? -1 :
                             $urandom_range(shadow_count, 0)),
                          pick_value());
            else if (roll < 8 + insert_share + remove_share)
                send_word(REQ_REMOVE,
                          8'((shadow_count == 0) ? 0 : $urandom_range(shadow_count - 1, 0)),
                          $urandom);
            else if (shadow_count > 0 && $urandom_range(9, 0) < 7)
                send_word(REQ_SEARCH, 8'($urandom_range(255, 0)),
                          shadow_list[$urandom_range(shadow_count - 1, 0)]);
            else
                send_word(REQ_SEARCH, 8'($urandom_range(255, 0)), pick_value());
        end
        steady = 1'b0;
    endtask

    // Hold the sender until every reply is in, then resume from a quiet block.
    task automatic test_quiet_sender();
        int k;
        wait_for_replies();
        for (k = 0; k < 12; k++)
            send_word(2'($urandom_range(2, 0)),
                      8'(int'($urandom_range(shadow_count + 1, 0)) - 1),
                      pick_value());
    endtask

    always @(posedge clk)
    begin
        list_reply_t want;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                errors++;
                $error("reply with no request pending");
            end
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.status)
                begin
                    errors++;
                    $error("status: expected %0d, got %0d", want.status, status);
                end
                if (found !== want.found)
                begin
                    errors++;
                    $error("found: expected %0d, got %0d", want.found, found);
                end
                if (found_index !== want.found_index)
                begin
                    errors++;
                    $error("found_index: expected %0d, got %0d", want.found_index, found_index);
                end
                if (count !== want.count)
                begin
                    errors++;
                    $error("count: expected %0d, got %0d", want.count, count);
                end
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_capacity();
        test_quiet_sender();
        test_random();
        test_quiet_sender();
        wait_for_replies();
        repeat (80) @(posedge clk);
        if (errors == 0 && pending_replies.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
